### hw/rtl/rte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_pkg: shared types and constants
// Word layouts, operand codes and the command/status bundles that pass
// between the rectangle-to-tile controller and its datapath.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int unsigned TILE_SIZE_W      = 15;
  localparam logic [14:0] TILE_SIZE_RESET  = 15'd256;
  localparam int unsigned MAX_SPAN_DEFAULT = 8;

  // operand width: sign-extended corner coordinate, kept even for radix-4 steps
  localparam int unsigned OPND_W  = 34;
  localparam int unsigned FLOOR_W = OPND_W + 1;

  // division operands, in the order they are worked through
  localparam logic [1:0] OP_X0 = 2'd0;
  localparam logic [1:0] OP_Y0 = 2'd1;
  localparam logic [1:0] OP_X1 = 2'd2;
  localparam logic [1:0] OP_Y1 = 2'd3;

  typedef struct packed {
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic        [15:0] rect_width;
    logic        [15:0] rect_height;
  } rect_t;

  typedef struct packed {
    logic signed [31:0] tile_col;
    logic signed [31:0] tile_row;
    logic               last_tile;
    logic               span_overflow;
  } tile_t;

  typedef struct packed {
    logic       load;       // latch the rectangle word
    logic       div_start;  // launch a division on operand op_sel
    logic [1:0] op_sel;
    logic       div_store;  // keep the finished floor quotient
    logic       emit_ovf;   // send the overflow word
    logic       enum_init;  // set up the tile walk
    logic       emit_tile;  // send one tile word and advance
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;      // incoming rectangle has no area
    logic div_done;
    logic span_ovf;   // corner out of range or span too large
    logic last_tile;  // current tile is the final one
  } ctrl_status_t;

endpackage

### hw/rtl/rte_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_div: serial unsigned divider
// Restoring division, two quotient bits per cycle, by a tile size.
// ----------------------------------------------------------------------------
module rte_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [rte_pkg::OPND_W-1:0]           dividend_i,
  input  logic [rte_pkg::TILE_SIZE_W-1:0]      divisor_i,
  output logic                                 done_o,
  output logic [rte_pkg::OPND_W-1:0]           quot_o,
  output logic                                 rem_nz_o
);

  localparam int unsigned Steps = rte_pkg::OPND_W / 2;
  localparam int unsigned CntW  = $clog2(Steps);
  localparam int unsigned DW    = rte_pkg::TILE_SIZE_W;

  logic [DW-1:0]                 div_q;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [rte_pkg::OPND_W-1:0]    quo_q, quo_d;
  logic [CntW-1:0]               cnt_q;
  logic                          run_q, done_q;

  logic [DW:0]   sh1, sh2;
  logic [DW-1:0] r1;
  logic          ge1, ge2;

  always_comb begin
    sh1   = {rem_q, quo_q[rte_pkg::OPND_W-1]};
    ge1   = sh1 >= {1'b0, div_q};
    r1    = ge1 ? DW'(sh1 - {1'b0, div_q}) : sh1[DW-1:0];
    sh2   = {r1, quo_q[rte_pkg::OPND_W-2]};
    ge2   = sh2 >= {1'b0, div_q};
    rem_d = ge2 ? DW'(sh2 - {1'b0, div_q}) : sh2[DW-1:0];
    quo_d = {quo_q[rte_pkg::OPND_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Steps - 1);
    end else if (run_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = rem_q != '0;

endmodule

### hw/rtl/rte_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_datapath: corner arithmetic and tile walk
// Holds tile size, rectangle word, floor quotients, span offsets and the
// output register.
// ----------------------------------------------------------------------------
module rte_datapath #(
  parameter int unsigned MaxSpan = rte_pkg::MAX_SPAN_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rte_pkg::TILE_SIZE_W-1:0]     cfg_wdata_i,
  input  rte_pkg::rect_t                      rect_i,
  input  rte_pkg::ctrl_cmd_t                  cmd_i,
  output rte_pkg::ctrl_status_t               status_o,
  output rte_pkg::tile_t                      tile_o,
  output logic                                tile_valid_o
);

  localparam int unsigned SpanW = (MaxSpan > 1) ? $clog2(MaxSpan) : 1;
  localparam int unsigned FW    = rte_pkg::FLOOR_W;
  localparam int unsigned OW    = rte_pkg::OPND_W;
  localparam logic signed [FW-1:0] IdxMax  = FW'(33'sh07FFFFFFF);
  localparam logic signed [FW-1:0] SpanLim = FW'(MaxSpan);

  function automatic logic signed [OW-1:0] corner(rte_pkg::rect_t r, logic [1:0] sel);
    logic signed [OW-1:0] xs, ys;
    xs = OW'(r.rect_x);
    ys = OW'(r.rect_y);
    case (sel)
      rte_pkg::OP_X0: return xs;
      rte_pkg::OP_Y0: return ys;
      rte_pkg::OP_X1: return xs + $signed({2'b0, 16'b0, r.rect_width}) - OW'(1);
      rte_pkg::OP_Y1: return ys + $signed({2'b0, 16'b0, r.rect_height}) - OW'(1);
      default:        return xs;
    endcase
  endfunction

  logic [rte_pkg::TILE_SIZE_W-1:0] tile_size_q;
  rte_pkg::rect_t                  rect_q;
  logic [1:0]                      op_run_q;
  logic signed [31:0]              c0_q, r0_q;
  logic signed [FW-1:0]            c1_q, r1_q;
  logic [SpanW-1:0]                col_span_q, row_span_q, col_off_q, row_off_q;
  rte_pkg::tile_t                  tile_q;
  logic                            valid_q;

  rte_pkg::rect_t                  src_rect;
  logic signed [OW-1:0]            start_opnd, store_opnd;
  logic [OW-1:0]                   mag;
  logic [rte_pkg::TILE_SIZE_W-1:0] divisor;
  logic                            div_done, rem_nz;
  logic [OW-1:0]                   quot;
  logic signed [FW-1:0]            qv, floor_val, cdiff, rdiff;
  logic                            last_here;

  // a zero tile size behaves as one
  assign divisor  = (tile_size_q == '0) ? rte_pkg::TILE_SIZE_W'(1) : tile_size_q;
  assign src_rect = cmd_i.load ? rect_i : rect_q;

  always_comb begin
    start_opnd = corner(src_rect, cmd_i.op_sel);
    mag        = start_opnd[OW-1] ? OW'(-start_opnd) : OW'(start_opnd);
    store_opnd = corner(rect_q, op_run_q);
    qv         = $signed({1'b0, quot});
    floor_val  = store_opnd[OW-1] ? -(qv + FW'(rem_nz)) : qv;
    cdiff      = c1_q - FW'(c0_q);
    rdiff      = r1_q - FW'(r0_q);
    last_here  = (col_off_q == col_span_q) && (row_off_q == row_span_q);
  end

  rte_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(mag),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_nz_o  (rem_nz)
  );

  always_comb begin
    status_o.empty     = (rect_i.rect_width == '0) || (rect_i.rect_height == '0);
    status_o.div_done  = div_done;
    status_o.span_ovf  = (c1_q > IdxMax) || (r1_q > IdxMax) ||
                         (cdiff >= SpanLim) || (rdiff >= SpanLim);
    status_o.last_tile = last_here;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= rte_pkg::TILE_SIZE_RESET;
      valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tile_size_q <= cfg_wdata_i;
      end
      valid_q <= cmd_i.emit_ovf || cmd_i.emit_tile;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rect_q <= rect_i;
    end
    if (cmd_i.div_start) begin
      op_run_q <= cmd_i.op_sel;
    end
    if (cmd_i.div_store) begin
      case (op_run_q)
        rte_pkg::OP_X0: c0_q <= floor_val[31:0];
        rte_pkg::OP_Y0: r0_q <= floor_val[31:0];
        rte_pkg::OP_X1: c1_q <= floor_val;
        rte_pkg::OP_Y1: r1_q <= floor_val;
        default:        c0_q <= floor_val[31:0];
      endcase
    end
    if (cmd_i.enum_init) begin
      col_span_q <= cdiff[SpanW-1:0];
      row_span_q <= rdiff[SpanW-1:0];
      col_off_q  <= '0;
      row_off_q  <= '0;
    end else if (cmd_i.emit_tile) begin
      if (col_off_q == col_span_q) begin
        col_off_q <= '0;
        row_off_q <= row_off_q + SpanW'(1);
      end else begin
        col_off_q <= col_off_q + SpanW'(1);
      end
    end
    if (cmd_i.emit_ovf) begin
      tile_q.tile_col      <= '0;
      tile_q.tile_row      <= '0;
      tile_q.last_tile     <= 1'b1;
      tile_q.span_overflow <= 1'b1;
    end else if (cmd_i.emit_tile) begin
      tile_q.tile_col      <= c0_q + 32'(col_off_q);
      tile_q.tile_row      <= r0_q + 32'(row_off_q);
      tile_q.last_tile     <= last_here;
      tile_q.span_overflow <= 1'b0;
    end
  end

  assign tile_o       = tile_q;
  assign tile_valid_o = valid_q;

endmodule

### hw/rtl/rte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_ctrl: sequencing state machine
// Runs the four corner divisions, the range check and the tile walk.
// ----------------------------------------------------------------------------
module rte_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  rte_pkg::ctrl_status_t status_i,
  output rte_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        // drop empty rectangles on the spot
        if (start && !status_i.empty) begin
          cmd_o.load      = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.op_sel    = rte_pkg::OP_X0;
          op_d            = rte_pkg::OP_X0;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (op_q == rte_pkg::OP_Y1) begin
            state_d = ST_CHECK;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.op_sel    = op_q + 2'd1;
            op_d            = op_q + 2'd1;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.span_ovf) begin
          cmd_o.emit_ovf = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.enum_init = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_tile = 1'b1;
        if (status_i.last_tile) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= rte_pkg::OP_X0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy = state_q != ST_IDLE;

endmodule

### hw/rtl/rect_to_tile_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_to_tile_enumerator: list the square tiles a rectangle overlaps
// Command in, strobed tile words out; tile size set through one register.
// ----------------------------------------------------------------------------
// Use:
//   Input: present a rectangle word on rect_i with start high; it is taken
//   at the clock edge where start is high and busy is low. A rectangle of
//   zero width or height is taken and dropped, and busy stays low.
//   Output: each tile word shows on tile_o for exactly one cycle with
//   tile_valid_o high, row by row and left to right. last_tile marks the
//   final word of a rectangle. A rectangle spanning more than MaxSpan tiles
//   on either axis, or whose far tile index leaves 32 signed bits, gives one
//   word with span_overflow and last_tile set and zero coordinates.
//   The receiver cannot stall: words are sent whether taken or not.
// Timing:
//   Four floor divisions by the tile size share one serial divider that
//   retires two quotient bits a cycle, one corner after another; the
//   range check follows, then the words, one word a cycle (up to MaxSpan
//   squared). Busy falls as the last word is registered, so a new
//   rectangle may be taken while that word is still on the port.
// Reset:
//   Returns to idle with the tile size at 256 pixels; a tile size of zero
//   written later acts as one. Write cfg_we_i/cfg_wdata_i only while idle.
// ----------------------------------------------------------------------------
module rect_to_tile_enumerator #(
  parameter int unsigned MaxSpan = rte_pkg::MAX_SPAN_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  rte_pkg::rect_t                   rect_i,
  output rte_pkg::tile_t                   tile_o,
  output logic                             tile_valid_o,
  input  logic                             cfg_we_i,
  input  logic [rte_pkg::TILE_SIZE_W-1:0]  cfg_wdata_i
);

  rte_pkg::ctrl_cmd_t    cmd;
  rte_pkg::ctrl_status_t status;

  // sequencer: hold the walk order, advance on divider completion
  rte_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  // arithmetic, tile size register and the output word register
  rte_datapath #(
    .MaxSpan(MaxSpan)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rect_i      (rect_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .tile_o      (tile_o),
    .tile_valid_o(tile_valid_o)
  );

endmodule

### sim/tb_rect_to_tile_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_to_tile_enumerator: self-checking bench for the tile enumerator
// Feeds rectangle words through the start/busy handshake, predicts every
// tile word from a behavioural floor-division walk and checks each strobed
// word in order. Runs directed corners, then random rectangles under a
// range of tile sizes written between phases.
// ----------------------------------------------------------------------------
module tb_rect_to_tile_enumerator;

  localparam int MAX_SPAN = int'(rte_pkg::MAX_SPAN_DEFAULT);
  // drop-out guard and the quiet time that covers the divider latency
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned IDLE_PCT     = 27;

  logic           clk_i;
  logic           rst_ni    = 1'b0;
  logic           start_drv = 1'b0;
  rte_pkg::rect_t rect_drv  = '0;
  logic           cfg_we    = 1'b0;
  logic [14:0]    cfg_wdata = '0;
  logic           busy;
  rte_pkg::tile_t tile_out;
  logic           tile_valid;

  rte_pkg::rect_t rect_pend_q[$];   // rectangle words waiting for the driver
  rte_pkg::tile_t tile_exp_q[$];    // tile words still owed by the block
  logic [14:0]    tile_size_cur = rte_pkg::TILE_SIZE_RESET;
  logic           no_idle       = 1'b0;
  int unsigned    err_cnt       = 0;
  int unsigned    cycle_cnt     = 0;

  // bounds of the last rectangle walked, kept like the block's own registers
  logic [31:0] walk_first_col = '0;
  logic [31:0] walk_last_col  = '0;
  logic [31:0] walk_last_row  = '0;
  logic [31:0] walk_col       = '0;
  logic [31:0] walk_row       = '0;

  rect_to_tile_enumerator #(
    .MaxSpan(MAX_SPAN)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start_drv),
    .busy        (busy),
    .rect_i      (rect_drv),
    .tile_o      (tile_out),
    .tile_valid_o(tile_valid),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Floor division rounding toward minus infinity, divisor always positive.
  function automatic longint floor_tiles(input longint v, input longint s);
    if (v >= 0) return v / s;
    return -(((-v) + s - 1) / s);
  endfunction

  // Work out every tile word one rectangle causes and queue them in order.
  task automatic predict_tiles(input rte_pkg::rect_t r);
    longint s, x0, y0, x1, y1, c0, r0, c1, r1, rr, cc;
    rte_pkg::tile_t t;
    // empty rectangle: nothing owed, walk state untouched
    if (r.rect_width == 16'd0 || r.rect_height == 16'd0) return;
    s  = (tile_size_cur == 15'd0) ? 64'sd1 : longint'({49'd0, tile_size_cur});
    x0 = $signed(r.rect_x);
    y0 = $signed(r.rect_y);
    // far corner in 64 bits so that it cannot wrap
    x1 = x0 + longint'({48'd0, r.rect_width}) - 1;
    y1 = y0 + longint'({48'd0, r.rect_height}) - 1;
    c0 = floor_tiles(x0, s);
    r0 = floor_tiles(y0, s);
    c1 = floor_tiles(x1, s);
    r1 = floor_tiles(y1, s);
    // far index out of range or span too wide: one overflow word only
    if (c1 > 64'sd2147483647 || r1 > 64'sd2147483647 ||
        c1 - c0 + 1 > MAX_SPAN || r1 - r0 + 1 > MAX_SPAN) begin
      t = '0;
      t.last_tile     = 1'b1;
      t.span_overflow = 1'b1;
      tile_exp_q.insert(tile_exp_q.size(), t);
      return;
    end
    walk_first_col = c0[31:0];
    walk_last_col  = c1[31:0];
    walk_last_row  = r1[31:0];
    for (rr = r0; rr <= r1; rr++) begin
      for (cc = c0; cc <= c1; cc++) begin
        walk_col        = cc[31:0];
        walk_row        = rr[31:0];
        t.tile_col      = walk_col;
        t.tile_row      = walk_row;
        t.last_tile     = (rr == r1 && cc == c1);
        t.span_overflow = 1'b0;
        tile_exp_q.insert(tile_exp_q.size(), t);
      end
    end
  endtask

  // Driver: present the head of the pending queue, hold it while busy, and
  // retire it at the edge that takes it. Idle at random between words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_drv <= 1'b0;
      rect_drv  <= '0;
    end else begin
      if (start_drv && !busy) begin
        // word taken at this edge: predict from what was on the port
        predict_tiles(rect_drv);
        rect_pend_q.delete(0);
      end
      // hold start and the word unchanged while the block is busy
      if (!(start_drv && busy)) begin
        if (rect_pend_q.size() != 0 &&
            (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          start_drv <= 1'b1;
          rect_drv  <= rect_pend_q[0];
        end else begin
          start_drv <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, name, $signed(want), want, $signed(got), got);
      err_cnt++;
    end
  endtask

  // Monitor: every strobed word must match the oldest word still owed.
  rte_pkg::tile_t tile_want;
  always @(posedge clk_i) begin
    if (rst_ni && tile_valid) begin
      if (tile_exp_q.size() == 0) begin
        $display("%0t ns: unexpected tile word, expected none, ",
                 "actual col %0d row %0d last %0b ovf %0b",
                 $time, tile_out.tile_col, tile_out.tile_row,
                 tile_out.last_tile, tile_out.span_overflow);
        err_cnt++;
      end else begin
        tile_want = tile_exp_q.pop_front();
        check_field("tile_col", tile_want.tile_col, tile_out.tile_col);
        check_field("tile_row", tile_want.tile_row, tile_out.tile_row);
        check_field("last_tile", {31'd0, tile_want.last_tile},
                    {31'd0, tile_out.last_tile});
        check_field("span_overflow", {31'd0, tile_want.span_overflow},
                    {31'd0, tile_out.span_overflow});
      end
    end
  end

  // Drop out if the run hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("** rect_to_tile_enumerator: FAILED **");
      $finish;
    end
  end

  // Origin: anywhere, near zero, near either extreme, or on a tile boundary.
  function automatic logic [31:0] pick_origin(input int unsigned s);
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return int'($urandom_range(0, 8 * s)) - 4 * int'(s);
      2:       return 32'h7FFF_FFFF - $urandom_range(0, 70000);
      3:       return 32'h8000_0000 + $urandom_range(0, 70000);
      default: return (int'($urandom_range(0, 1000)) - 500) * int'(s);
    endcase
  endfunction

  // Extent that covers at most eight tiles whatever the offset in the tile.
  function automatic logic [15:0] pick_extent(input int unsigned s);
    int unsigned lim;
    lim = $urandom_range(1, 7) * s;
    if (lim > 65535) lim = 65535;
    return 16'($urandom_range(1, lim));
  endfunction

  function automatic rte_pkg::rect_t random_rect(input logic [14:0] ts);
    int unsigned    s, kind, wide;
    rte_pkg::rect_t r;
    s    = (ts == 15'd0) ? 1 : ts;
    kind = $urandom_range(0, 99);
    r.rect_x = pick_origin(s);
    r.rect_y = pick_origin(s);
    if (kind < 78) begin
      r.rect_width  = pick_extent(s);
      r.rect_height = pick_extent(s);
    end else if (kind < 90) begin
      // raw noise: all extent bits, mostly overflow
      r.rect_width  = 16'($urandom());
      r.rect_height = 16'($urandom());
    end else if (kind < 95) begin
      // one axis just past the span limit
      wide = 8 * s + $urandom_range(1, s);
      if (wide > 65535) wide = 65535;
      r.rect_width  = $urandom_range(0, 1) ? 16'(wide) : pick_extent(s);
      r.rect_height = (r.rect_width == 16'(wide)) ? pick_extent(s) : 16'(wide);
    end else begin
      r.rect_width  = $urandom_range(0, 2) == 0 ? 16'd0 : pick_extent(s);
      r.rect_height = r.rect_width == 16'd0 ? 16'($urandom()) : 16'd0;
    end
    return r;
  endfunction

  task automatic add_rect(input logic [31:0] x, input logic [31:0] y,
                          input logic [15:0] w, input logic [15:0] h);
    rte_pkg::rect_t r;
    r.rect_x      = x;
    r.rect_y      = y;
    r.rect_width  = w;
    r.rect_height = h;
    rect_pend_q.insert(rect_pend_q.size(), r);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) rect_pend_q.insert(rect_pend_q.size(), random_rect(tile_size_cur));
  endtask

  // Wait until every word is taken and answered, then let the divider settle.
  task automatic drain();
    do @(negedge clk_i);
    while (rect_pend_q.size() != 0 || start_drv || busy || tile_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write the tile size while idle and track it in the predictor.
  task automatic write_tile_size(input logic [14:0] v);
    drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tile_size_cur = v;
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed corners, then random phases over tile sizes.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset tile size of 256: empties, boundaries, full 8x8 walk, spans
    add_rect(32'd0, 32'd0, 16'd0, 16'd10);
    add_rect(32'd0, 32'd0, 16'd10, 16'd0);
    add_rect(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0);
    add_rect(32'd0, 32'd0, 16'd1, 16'd1);
    add_rect(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'd1);
    add_rect(-32'sd256, -32'sd257, 16'd256, 16'd1);
    add_rect(32'd255, 32'd255, 16'd2, 16'd2);
    add_rect(32'd0, 32'd0, 16'd2048, 16'd2048);
    add_rect(32'd0, 32'd0, 16'd2049, 16'd1);
    add_rect(32'd0, 32'd0, 16'd1, 16'd2049);
    add_rect(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1, 16'd1);
    add_rect(32'h7FFF_FFFF, 32'd0, 16'd256, 16'd1);
    add_rect(32'h8000_0000, 32'h8000_0000, 16'd1, 16'd1);
    add_rect(32'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    add_rect(-32'sd1000, 32'd500, 16'd1000, 16'd300);
    add_random(30);

    // unit tiles: far index just inside and just outside 32 signed bits
    write_tile_size(15'd1);
    add_rect(32'h7FFF_FFFF, 32'd0, 16'd1, 16'd1);
    add_rect(32'h7FFF_FFFF, 32'd0, 16'd2, 16'd1);
    add_rect(32'd0, 32'h7FFF_FFFF, 16'd1, 16'd2);
    add_rect(32'h8000_0000, 32'h8000_0000, 16'd8, 16'd8);
    add_rect(-32'sd4, -32'sd4, 16'd8, 16'd9);
    add_random(30);

    // zero tile size behaves as one
    write_tile_size(15'd0);
    add_rect(32'h7FFF_FFFF, 32'd0, 16'd2, 16'd1);
    add_rect(-32'sd5, 32'd7, 16'd3, 16'd2);
    add_random(30);

    // widest tiles: full 16-bit extents stay within the span limit
    write_tile_size(15'h7FFF);
    add_rect(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_random(30);

    // back-to-back words with no idling at all
    write_tile_size(15'd16384);
    no_idle = 1'b1;
    add_random(30);
    drain();
    no_idle = 1'b0;

    write_tile_size(15'd3);
    add_random(30);
    write_tile_size(15'($urandom_range(1, 32767)));
    add_random(30);
    write_tile_size(15'($urandom_range(2, 64)));
    add_random(30);
    write_tile_size(rte_pkg::TILE_SIZE_RESET);
    add_random(30);

    drain();
    if (tile_exp_q.size() != 0) begin
      $display("%0t ns: %0d tile words never arrived", $time, tile_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** rect_to_tile_enumerator: PASSED **");
    end else begin
      $display("** rect_to_tile_enumerator: FAILED **");
    end
    $finish;
  end

endmodule
